>>> rtl/rrts_pkg.sv
// Shared types and constants for the round-robin tick scheduler.
// No dependencies; used by every module under rtl/.
package rrts_pkg;

  // Task table and ready queue depth (power of two, queue pointers wrap)
  localparam int MaxTasks = 16;
  localparam int TaskW    = $clog2(MaxTasks);
  localparam int CntW     = $clog2(MaxTasks + 1);

  // Field widths
  localparam int QuantumW = 8;
  localparam int BurstW   = 8;
  localparam int TickW    = 32;

  localparam logic [QuantumW-1:0] QuantumReset = QuantumW'(5);

  // Input word kinds
  localparam logic KindLoad = 1'b0;
  localparam logic KindTick = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_READ,
    S_EXEC,
    S_EMPTY
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_en;   // accepted load word
    logic tick_en;   // accepted tick word
    logic pop_rd;    // read queue head
    logic pop_take;  // dispatch the task just read
    logic burst_rd;  // read burst tables for current task
    logic exec;      // run one tick and load the result word
    logic empty_out; // load an all-done result word
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_dispatch;
    logic fifo_empty;
    logic out_free;
  } status_t;

endpackage

>>> rtl/rrts_ctrl.sv
// Sequencing state machine for the round-robin tick scheduler.
// Depends on rrts_pkg; drives commands into rrts_datapath.
module rrts_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             kind_i,
  input  rrts_pkg::status_t sts_i,
  output rrts_pkg::cmd_t    cmd_o
);

  rrts_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrts_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != rrts_pkg::S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      rrts_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (kind_i == rrts_pkg::KindLoad) begin
            cmd_o.load_en = 1'b1;
          end else begin
            cmd_o.tick_en = 1'b1;
            priority if (sts_i.need_dispatch && sts_i.fifo_empty) begin
              state_d = rrts_pkg::S_EMPTY;
            end else if (sts_i.need_dispatch) begin
              cmd_o.pop_rd = 1'b1;
              state_d      = rrts_pkg::S_POP;
            end else begin
              cmd_o.burst_rd = 1'b1;
              state_d        = rrts_pkg::S_EXEC;
            end
          end
        end
      end
      rrts_pkg::S_POP: begin
        cmd_o.pop_take = 1'b1;
        state_d        = rrts_pkg::S_READ;
      end
      rrts_pkg::S_READ: begin
        cmd_o.burst_rd = 1'b1;
        state_d        = rrts_pkg::S_EXEC;
      end
      rrts_pkg::S_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = rrts_pkg::S_IDLE;
        end
      end
      rrts_pkg::S_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.empty_out = 1'b1;
          state_d         = rrts_pkg::S_IDLE;
        end
      end
      default: state_d = rrts_pkg::S_IDLE;
    endcase
  end

endmodule

>>> rtl/rrts_datapath.sv
// Ready queue, burst tables, counters and result register of the scheduler.
// Depends on rrts_pkg; commanded by rrts_ctrl.
module rrts_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rrts_pkg::cmd_t                   cmd_i,
  output rrts_pkg::status_t                sts_o,
  input  logic                             cfg_we_i,
  input  logic [rrts_pkg::QuantumW-1:0]    cfg_wdata_i,
  input  logic [rrts_pkg::TaskW-1:0]       task_id_i,
  input  logic [rrts_pkg::BurstW-1:0]      burst_len_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [rrts_pkg::TaskW-1:0]       run_task_o,
  output logic                             ran_o,
  output logic [rrts_pkg::QuantumW-1:0]    quantum_left_o,
  output logic [rrts_pkg::BurstW-1:0]      burst_left_o,
  output logic                             finished_o,
  output logic [rrts_pkg::TickW-1:0]       wait_ticks_o,
  output logic                             all_done_o
);

  // Memories (no reset, never read before written)
  logic [rrts_pkg::TaskW-1:0]  fifo_mem [rrts_pkg::MaxTasks];
  logic [rrts_pkg::BurstW-1:0] btot_mem [rrts_pkg::MaxTasks];
  logic [rrts_pkg::BurstW-1:0] brem_mem [rrts_pkg::MaxTasks];

  logic [rrts_pkg::TaskW-1:0]    fifo_rd_q;
  logic [rrts_pkg::BurstW-1:0]   btot_rd_q, brem_rd_q;

  // Control and scheduling state
  logic [rrts_pkg::QuantumW-1:0] quantum_cfg_q;
  logic [rrts_pkg::TaskW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [rrts_pkg::CntW-1:0]     count_q, count_d;
  logic [rrts_pkg::TaskW-1:0]    cur_q, cur_d;
  logic [rrts_pkg::QuantumW-1:0] qrem_q, qrem_d;
  logic                          need_q, need_d;
  logic [rrts_pkg::TickW-1:0]    tick_q;

  // Result word
  logic                          out_valid_q;
  logic [rrts_pkg::TaskW-1:0]    run_task_q;
  logic                          ran_q, finished_q, all_done_q;
  logic [rrts_pkg::QuantumW-1:0] qleft_q;
  logic [rrts_pkg::BurstW-1:0]   bleft_q;
  logic [rrts_pkg::TickW-1:0]    wait_q;

  logic                          full, empty, load_ok, push_exec, out_free;
  logic [rrts_pkg::QuantumW-1:0] q_dec;
  logic [rrts_pkg::BurstW-1:0]   b_dec;
  logic                          done;
  logic [rrts_pkg::TickW-1:0]    wait_calc;

  assign full    = (count_q == rrts_pkg::CntW'(rrts_pkg::MaxTasks));
  assign empty   = (count_q == '0);
  assign load_ok = cmd_i.load_en && (burst_len_i != '0) && !full &&
                   (int'(task_id_i) < rrts_pkg::MaxTasks);

  // One tick of the running task
  assign q_dec     = (qrem_q == '0) ? '0 : qrem_q - 1'b1;
  assign b_dec     = (brem_rd_q == '0) ? '0 : brem_rd_q - 1'b1;
  assign done      = (b_dec == '0);
  assign wait_calc = tick_q - rrts_pkg::TickW'(btot_rd_q);
  assign push_exec = cmd_i.exec && !done && (q_dec == '0) && !full;

  assign out_free = !out_valid_q || !out_stall_i;
  assign sts_o    = '{need_dispatch: need_q, fifo_empty: empty, out_free: out_free};

  // Memory writes and registered reads
  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      fifo_mem[tail_q]    <= task_id_i;
      btot_mem[task_id_i] <= burst_len_i;
      brem_mem[task_id_i] <= burst_len_i;
    end
    if (push_exec) begin
      fifo_mem[tail_q] <= cur_q;
    end
    if (cmd_i.exec) begin
      brem_mem[cur_q] <= b_dec;
    end
    if (cmd_i.pop_rd) begin
      fifo_rd_q <= fifo_mem[head_q];
    end
    if (cmd_i.burst_rd) begin
      btot_rd_q <= btot_mem[cur_q];
      brem_rd_q <= brem_mem[cur_q];
    end
  end

  // Next values of queue pointers and running-task state
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    cur_d   = cur_q;
    qrem_d  = qrem_q;
    need_d  = need_q;
    if (load_ok || push_exec) begin
      tail_d  = tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end
    if (cmd_i.pop_take) begin
      head_d  = head_q + 1'b1;
      count_d = count_q - 1'b1;
      cur_d   = fifo_rd_q;
      qrem_d  = quantum_cfg_q;
      need_d  = 1'b0;
    end
    if (cmd_i.exec) begin
      qrem_d = q_dec;
      if (done) begin
        need_d = 1'b1;
      end else if (q_dec == '0) begin
        // quantum expired: refill, requeue if there is room
        qrem_d = quantum_cfg_q;
        if (!full) begin
          need_d = 1'b1;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_cfg_q <= rrts_pkg::QuantumReset;
      head_q        <= '0;
      tail_q        <= '0;
      count_q       <= '0;
      cur_q         <= '0;
      qrem_q        <= '0;
      need_q        <= 1'b1;
      tick_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        quantum_cfg_q <= cfg_wdata_i;
      end
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      cur_q   <= cur_d;
      qrem_q  <= qrem_d;
      need_q  <= need_d;
      if (cmd_i.tick_en) begin
        tick_q <= tick_q + 1'b1;
      end
      if (cmd_i.exec || cmd_i.empty_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result word payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      run_task_q <= cur_q;
      ran_q      <= 1'b1;
      qleft_q    <= q_dec;
      bleft_q    <= b_dec;
      finished_q <= done;
      wait_q     <= done ? wait_calc : '0;
      all_done_q <= 1'b0;
    end else if (cmd_i.empty_out) begin
      run_task_q <= '0;
      ran_q      <= 1'b0;
      qleft_q    <= '0;
      bleft_q    <= '0;
      finished_q <= 1'b0;
      wait_q     <= '0;
      all_done_q <= 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign run_task_o     = run_task_q;
  assign ran_o          = ran_q;
  assign quantum_left_o = qleft_q;
  assign burst_left_o   = bleft_q;
  assign finished_o     = finished_q;
  assign wait_ticks_o   = wait_q;
  assign all_done_o     = all_done_q;

endmodule

>>> rtl/round_robin_tick_scheduler.sv
// Round-robin tick scheduler. A load word is taken without leaving idle; in_stall_o then stays low.
// A tick word puts its result word in the output register from S_EXEC, after S_POP and S_READ
// when a task is dispatched from the ready queue (from S_EMPTY for an all-done word); in_stall_o is high until then.
// Loads are taken one per cycle while idle; a tick word stalls the input until its result word is loaded,
// held by the registered reads of the queue memory and the burst tables, plus output stalls.
// Async active-low reset: queue empty, quantum 5, dispatch pending, tick count 0.
module round_robin_tick_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rrts_pkg::QuantumW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [rrts_pkg::TaskW-1:0]    task_id_i,
  input  logic [rrts_pkg::BurstW-1:0]   burst_len_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rrts_pkg::TaskW-1:0]    run_task_o,
  output logic                          ran_o,
  output logic [rrts_pkg::QuantumW-1:0] quantum_left_o,
  output logic [rrts_pkg::BurstW-1:0]   burst_left_o,
  output logic                          finished_o,
  output logic [rrts_pkg::TickW-1:0]    wait_ticks_o,
  output logic                          all_done_o
);

  rrts_pkg::cmd_t    cmd;
  rrts_pkg::status_t sts;

  // Sequencer
  rrts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Queue, tables and result register
  rrts_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .task_id_i      (task_id_i),
    .burst_len_i    (burst_len_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .run_task_o     (run_task_o),
    .ran_o          (ran_o),
    .quantum_left_o (quantum_left_o),
    .burst_left_o   (burst_left_o),
    .finished_o     (finished_o),
    .wait_ticks_o   (wait_ticks_o),
    .all_done_o     (all_done_o)
  );

endmodule

>>> rtl/rrts_checker.sv
// Port-level checks for the round-robin tick scheduler, bound to the top level.
// Depends on rrts_pkg and round_robin_tick_scheduler.
module rrts_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [rrts_pkg::TaskW-1:0]    run_task_o,
  input logic                          ran_o,
  input logic [rrts_pkg::BurstW-1:0]   burst_left_o,
  input logic                          finished_o,
  input logic [rrts_pkg::TickW-1:0]    wait_ticks_o,
  input logic                          all_done_o
);

  // Stalled result word stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // Stalled result word keeps its task
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(run_task_o) && $stable(burst_left_o))
    else $error("stalled result word changed");

  // All-done word carries no task activity
  a_all_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && all_done_o |-> !ran_o && !finished_o && (wait_ticks_o == '0))
    else $error("all-done word with task activity");

  // Finish only when the burst has run out
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ran_o |-> (finished_o == (burst_left_o == '0)) && !all_done_o)
    else $error("finished flag disagrees with remaining burst");

  // Waiting time only reported on finish
  a_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !finished_o |-> (wait_ticks_o == '0))
    else $error("waiting time on unfinished task");

endmodule

bind round_robin_tick_scheduler rrts_checker u_rrts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .run_task_o   (run_task_o),
  .ran_o        (ran_o),
  .burst_left_o (burst_left_o),
  .finished_o   (finished_o),
  .wait_ticks_o (wait_ticks_o),
  .all_done_o   (all_done_o)
);

>>> tb/sv/round_robin_tick_scheduler_tb.sv
// Self-checking testbench for round_robin_tick_scheduler: directed and random load/tick words,
// a cycle-free scheduler predictor in a scoreboard class, random stalls on both channels.
// Depends on rtl/rrts_pkg.sv and rtl/round_robin_tick_scheduler.sv.
`timescale 1ns / 100ps

module round_robin_tick_scheduler_tb;
  import rrts_pkg::*;

  localparam int HalfPeriod = 2;
  localparam int ResetCycles = 7;
  localparam int StallLimit = 1000;
  localparam int PhaseWords = 155;

  // One tick report as the block presents it
  typedef struct packed {
    logic [TaskW-1:0]    run_task;
    logic                ran;
    logic [QuantumW-1:0] quantum_left;
    logic [BurstW-1:0]   burst_left;
    logic                finished;
    logic [TickW-1:0]    wait_ticks;
    logic                all_done;
  } tick_report_t;

  // Scheduler predictor and queue of tick reports still due
  class tick_scoreboard;
    logic [QuantumW-1:0] quantum;
    logic [TaskW-1:0]    ready_q [MaxTasks];
    logic [TaskW-1:0]    head;
    logic [TaskW-1:0]    tail;
    logic [CntW-1:0]     depth;
    logic [BurstW-1:0]   burst_total [MaxTasks];
    logic [BurstW-1:0]   burst_rem [MaxTasks];
    logic [TaskW-1:0]    running;
    logic [QuantumW-1:0] slice_left;
    bit                  dispatch_due;
    logic [TickW-1:0]    tick_count;
    tick_report_t        due_reports [$];
    int                  errors;

    function new();
      quantum      = QuantumReset;
      head         = '0;
      tail         = '0;
      depth        = '0;
      running      = '0;
      slice_left   = '0;
      dispatch_due = 1'b1;
      tick_count   = '0;
      errors       = 0;
      foreach (ready_q[i]) begin
        ready_q[i]     = '0;
        burst_total[i] = '0;
        burst_rem[i]   = '0;
      end
    endfunction

    function bit enqueue(logic [TaskW-1:0] id);
      if (depth == CntW'(MaxTasks)) return 1'b0;
      ready_q[tail] = id;
      tail++;
      depth++;
      return 1'b1;
    endfunction

    function int pending();
      return due_reports.size();
    endfunction

    // Apply one accepted word; returns 0 when the block ignores it
    function bit take_word(logic kind, logic [TaskW-1:0] id, logic [BurstW-1:0] burst);
      tick_report_t rep;
      logic [TaskW-1:0] t;
      bit unused;
      if (kind == KindLoad) begin
        if (burst == '0 || depth == CntW'(MaxTasks)) return 1'b0;
        burst_total[id] = burst;
        burst_rem[id]   = burst;
        unused = enqueue(id);
        return 1'b1;
      end
      tick_count++;
      rep = '0;
      if (dispatch_due) begin
        if (depth == '0) begin
          rep.all_done = 1'b1;
          due_reports.push_back(rep);
          return 1'b1;
        end
        running = ready_q[head];
        head++;
        depth--;
        slice_left   = quantum;
        dispatch_due = 1'b0;
      end
      t = running;
      // both counters saturate at zero
      if (slice_left != '0) slice_left--;
      if (burst_rem[t] != '0) burst_rem[t]--;
      rep.run_task     = t;
      rep.ran          = 1'b1;
      rep.quantum_left = slice_left;
      rep.burst_left   = burst_rem[t];
      if (burst_rem[t] == '0) begin
        rep.finished   = 1'b1;
        rep.wait_ticks = tick_count - TickW'(burst_total[t]);
        dispatch_due   = 1'b1;
      end else if (slice_left == '0) begin
        // preempt; a full queue leaves the task running on a fresh slice
        slice_left = quantum;
        if (enqueue(t)) dispatch_due = 1'b1;
      end
      due_reports.push_back(rep);
      return 1'b1;
    endfunction

    function void match(string field, logic [TickW-1:0] want, logic [TickW-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_tick(tick_report_t got);
      tick_report_t want;
      if (due_reports.size() == 0) begin
        $error("unexpected tick report: run_task %0d ran %0d", got.run_task, got.ran);
        errors++;
        return;
      end
      want = due_reports.pop_front();
      match("run_task", TickW'(want.run_task), TickW'(got.run_task));
      match("ran", TickW'(want.ran), TickW'(got.ran));
      match("quantum_left", TickW'(want.quantum_left), TickW'(got.quantum_left));
      match("burst_left", TickW'(want.burst_left), TickW'(got.burst_left));
      match("finished", TickW'(want.finished), TickW'(got.finished));
      match("wait_ticks", want.wait_ticks, got.wait_ticks);
      match("all_done", TickW'(want.all_done), TickW'(got.all_done));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [QuantumW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                kind_i;
  logic [TaskW-1:0]    task_id_i;
  logic [BurstW-1:0]   burst_len_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [TaskW-1:0]    run_task_o;
  logic                ran_o;
  logic [QuantumW-1:0] quantum_left_o;
  logic [BurstW-1:0]   burst_left_o;
  logic                finished_o;
  logic [TickW-1:0]    wait_ticks_o;
  logic                all_done_o;

  tick_scoreboard sb;
  bit sender_steady;
  bit receiver_steady;
  int sent_words;
  int quiet_cycles;

  round_robin_tick_scheduler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .task_id_i      (task_id_i),
    .burst_len_i    (burst_len_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .run_task_o     (run_task_o),
    .ran_o          (ran_o),
    .quantum_left_o (quantum_left_o),
    .burst_left_o   (burst_left_o),
    .finished_o     (finished_o),
    .wait_ticks_o   (wait_ticks_o),
    .all_done_o     (all_done_o)
  );

  initial clk_i = 1'b0;
  always #HalfPeriod clk_i = ~clk_i;

  function automatic int pause_len(bit steady);
    return steady ? 0 : int'($urandom_range(0, 11));
  endfunction

  // Send one word; starts and ends at a falling edge, valid stays high
  task automatic send_word(logic kind, logic [TaskW-1:0] id, logic [BurstW-1:0] burst);
    int gap;
    gap = pause_len(sender_steady);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    task_id_i   <= id;
    burst_len_i <= burst;
    do @(posedge clk_i); while (in_stall_o);
    void'(sb.take_word(kind, id, burst));
    sent_words++;
    @(negedge clk_i);
  endtask

  // Quantum writes only once every report has come back
  task automatic set_quantum(logic [QuantumW-1:0] q);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= q;
    @(posedge clk_i);
    sb.quantum = q;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random word: mostly short bursts, some full-range ones, a few zero-burst loads
  task automatic random_word(int load_pct);
    logic kind;
    logic [BurstW-1:0] burst;
    int pick;
    kind = ($urandom_range(0, 99) < load_pct) ? KindLoad : KindTick;
    pick = $urandom_range(0, 15);
    if (pick == 0) burst = '0;
    else if (pick == 1) burst = BurstW'($urandom_range(0, 255));
    else burst = BurstW'($urandom_range(1, 8));
    send_word(kind, TaskW'($urandom_range(0, MaxTasks - 1)), burst);
  endtask

  // Result side: random stall before each word
  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      n = pause_len(receiver_steady);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Report monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_tick('{run_task: run_task_o, ran: ran_o, quantum_left: quantum_left_o,
                      burst_left: burst_left_o, finished: finished_o,
                      wait_ticks: wait_ticks_o, all_done: all_done_o});
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("FAIL round_robin_tick_scheduler");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [QuantumW-1:0] quanta [8];
    int start;
    int load_pct;
    sb              = new();
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    kind_i          = KindLoad;
    task_id_i       = '0;
    burst_len_i     = '0;
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
    sent_words      = 0;
    quiet_cycles    = 0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset quantum: empty queue, zero burst, reload of a queued task
    send_word(KindTick, 4'hF, 8'hFF);
    send_word(KindLoad, 4'h0, 8'h00);
    send_word(KindLoad, 4'hF, 8'hFF);
    send_word(KindLoad, 4'hA, 8'h01);
    send_word(KindLoad, 4'hA, 8'h02);
    // preempt task 15, finish task 10, then its stale second entry
    repeat (8) send_word(KindTick, 4'h0, 8'h00);

    // Fill the queue, overflow a load, then preempt into a full queue
    set_quantum(8'd2);
    for (int i = 0; i < MaxTasks - 1; i++) send_word(KindLoad, TaskW'(i), BurstW'(i + 1));
    send_word(KindLoad, 4'h7, 8'h80);
    send_word(KindTick, 4'h0, 8'h00);
    send_word(KindLoad, 4'h3, 8'h09);
    send_word(KindTick, 4'h0, 8'h00);
    send_word(KindTick, 4'h0, 8'h00);

    // Random phases across quantum settings, extremes included
    quanta = '{8'd1, 8'd0, 8'd255, 8'd2, 8'd5, QuantumW'($urandom_range(1, 254)), 8'd3,
               QuantumW'($urandom_range(0, 255))};
    foreach (quanta[p]) begin
      set_quantum(quanta[p]);
      sender_steady   = ($urandom_range(0, 3) == 0);
      receiver_steady = ($urandom_range(0, 3) == 0);
      load_pct        = $urandom_range(10, 45);
      start           = sent_words;
      while (sent_words - start < PhaseWords) random_word(load_pct);
    end

    // Drain and let the block settle
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS round_robin_tick_scheduler");
    end else begin
      $display("FAIL round_robin_tick_scheduler");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rrts_pkg.sv
rtl/rrts_ctrl.sv
rtl/rrts_datapath.sv
rtl/round_robin_tick_scheduler.sv
rtl/rrts_checker.sv
tb/sv/round_robin_tick_scheduler_tb.sv
